// File: hw/rtl/ilir_pkg.sv
// ilir_pkg: shared types and codes for the indexed list block
// used by ilir_cell and indexed_list_insert_remove; no dependencies
`timescale 1ns / 1ps

package ilir_pkg;

  // widths fixed by the request and result beats
  localparam int MODE_W   = 3;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_READ   = 3'd2,
    MODE_WRITE  = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // slot update applied by every cell in the same cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_WRITE  = 2'd3
  } cell_op_e;

  // command broadcast along the chain of cells
  typedef struct packed {
    cell_op_e           op;
    logic               load_rd;
    logic               shift_rd;
    logic [POS_W-1:0]   pos;
  } cell_cmd_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SHIFT = 2'd1,
    ST_EMIT  = 2'd2
  } ctrl_state_e;

endpackage

// File: hw/rtl/ilir_cell.sv
// ilir_cell: one list slot plus one stage of the read-out shift chain
// depends on ilir_pkg for the command struct and cell op codes
`timescale 1ns / 1ps

module ilir_cell #(
  parameter int IDX        = 0,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                  clk_i,
  input  ilir_pkg::cell_cmd_t   cmd_i,
  input  logic [ELEM_WIDTH-1:0] val_i,
  input  logic [ELEM_WIDTH-1:0] left_i,
  input  logic [ELEM_WIDTH-1:0] right_i,
  input  logic [ELEM_WIDTH-1:0] rd_next_i,
  output logic [ELEM_WIDTH-1:0] slot_o,
  output logic [ELEM_WIDTH-1:0] rd_o
);
  import ilir_pkg::*;

  // this cell's index as seen by a 5-bit position
  localparam bit              InRange = (IDX < (1 << POS_W));
  localparam logic [POS_W-1:0] IdxLo  = POS_W'(IDX % (1 << POS_W));

  logic [ELEM_WIDTH-1:0] slot_q, slot_d;
  logic [ELEM_WIDTH-1:0] rd_q, rd_d;
  logic                  at_pos, above_pos;

  // position compare
  assign at_pos    = InRange && (cmd_i.pos == IdxLo);
  assign above_pos = !InRange || (IdxLo > cmd_i.pos);

  // slot update from the neighbors or the request value
  always_comb begin
    slot_d = slot_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (above_pos) begin
          slot_d = left_i;
        end else if (at_pos) begin
          slot_d = val_i;
        end
      end
      CELL_REMOVE: begin
        if (above_pos || at_pos) begin
          slot_d = right_i;
        end
      end
      CELL_WRITE: begin
        if (at_pos) begin
          slot_d = val_i;
        end
      end
      default: begin
        slot_d = slot_q;
      end
    endcase
  end

  // read chain: snapshot the slot, then move toward cell zero
  always_comb begin
    rd_d = rd_q;
    if (cmd_i.load_rd) begin
      rd_d = slot_q;
    end else if (cmd_i.shift_rd) begin
      rd_d = rd_next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    rd_q   <= rd_d;
  end

  assign slot_o = slot_q;
  assign rd_o   = rd_q;

endmodule

// File: hw/rtl/indexed_list_insert_remove.sv
// indexed_list_insert_remove: ordered list held in a chain of slot cells
// the result beat is given in ST_EMIT, entered from ST_IDLE on acceptance; a read or remove that
// succeeds at a nonzero position first passes through ST_SHIFT, where the read chain moves the
// entry one cell per cycle to cell zero; a new request is accepted only in ST_IDLE, and
// busy_o stays high through the result beat, which is strobed on result_valid_o
// reset clears the count and the controller, not the slots; the receiver cannot stall
`timescale 1ns / 1ps

module indexed_list_insert_remove #(
  parameter int CAPACITY   = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [ilir_pkg::MODE_W-1:0]     mode_i,
  input  logic [ilir_pkg::POS_W-1:0]      position_i,
  input  logic [ilir_pkg::DATA_W-1:0]     element_value_i,
  output logic                            result_valid_o,
  output logic [ilir_pkg::DATA_W-1:0]     data_out_o,
  output logic [ilir_pkg::STATUS_W-1:0]   status_o,
  output logic [ilir_pkg::COUNT_W-1:0]    item_count_o
);
  import ilir_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMPW  = (CW > POS_W) ? CW : POS_W;
  localparam int CopyW = (ELEM_WIDTH < DATA_W) ? ELEM_WIDTH : DATA_W;

  ctrl_state_e           state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  status_e               status_q, status_d;
  logic                  has_data_q, has_data_d;
  logic [POS_W-1:0]      shift_q, shift_d;
  logic                  accept;
  cell_cmd_t             cmd;
  logic [ELEM_WIDTH-1:0] elem;
  logic [CMPW-1:0]       pos_x, cnt_x;
  logic                  full;
  logic [DATA_W-1:0]     rd_word;

  logic [ELEM_WIDTH-1:0] slot [CAPACITY];
  logic [ELEM_WIDTH-1:0] rd   [CAPACITY];

  assign accept = start_i && (state_q == ST_IDLE);
  assign pos_x  = CMPW'(position_i);
  assign cnt_x  = CMPW'(count_q);
  assign full   = (count_q == CW'(CAPACITY));

  // request value trimmed to the element width
  always_comb begin
    elem = '0;
    elem[CopyW-1:0] = element_value_i[CopyW-1:0];
  end

  // decode the request against the current count
  always_comb begin
    cmd        = '{op: CELL_HOLD, load_rd: 1'b0, shift_rd: 1'b0, pos: position_i};
    count_d    = count_q;
    status_d   = status_q;
    has_data_d = has_data_q;
    shift_d    = shift_q;
    if (accept) begin
      status_d   = STATUS_OK;
      has_data_d = 1'b0;
      shift_d    = position_i;
      cmd.load_rd = 1'b1;
      case (mode_e'(mode_i))
        MODE_INSERT: begin
          if (pos_x > cnt_x) begin
            status_d = STATUS_RANGE;
          end else if (full) begin
            status_d = STATUS_FULL;
          end else begin
            cmd.op  = CELL_INSERT;
            count_d = count_q + CW'(1);
          end
        end
        MODE_REMOVE: begin
          if (pos_x >= cnt_x) begin
            status_d = STATUS_RANGE;
          end else begin
            cmd.op     = CELL_REMOVE;
            count_d    = count_q - CW'(1);
            has_data_d = 1'b1;
          end
        end
        MODE_READ: begin
          if (pos_x >= cnt_x) begin
            status_d = STATUS_RANGE;
          end else begin
            has_data_d = 1'b1;
          end
        end
        MODE_WRITE: begin
          if (pos_x >= cnt_x) begin
            status_d = STATUS_RANGE;
          end else begin
            cmd.op = CELL_WRITE;
          end
        end
        MODE_CLEAR: begin
          count_d = '0;
        end
        default: begin
          status_d = STATUS_OK;
        end
      endcase
    end else if (state_q == ST_SHIFT) begin
      cmd.shift_rd = 1'b1;
      shift_d      = shift_q - POS_W'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (has_data_d && (position_i != '0)) begin
            state_d = ST_SHIFT;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SHIFT: begin
        if (shift_q == POS_W'(1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    has_data_q <= has_data_d;
    shift_q    <= shift_d;
  end

  // chain of slot cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left, right, rd_next;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = slot[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right   = '0;
      assign rd_next = '0;
    end else begin : g_right
      assign right   = slot[i+1];
      assign rd_next = rd[i+1];
    end
    ilir_cell #(
      .IDX        (i),
      .ELEM_WIDTH (ELEM_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .val_i     (elem),
      .left_i    (left),
      .right_i   (right),
      .rd_next_i (rd_next),
      .slot_o    (slot[i]),
      .rd_o      (rd[i])
    );
  end

  // read word taken from the head of the read chain
  always_comb begin
    rd_word = '0;
    rd_word[CopyW-1:0] = rd[0][CopyW-1:0];
  end

  // outputs
  always_comb begin
    busy_o         = (state_q != ST_IDLE);
    result_valid_o = (state_q == ST_EMIT);
    data_out_o     = has_data_q ? rd_word : '0;
    status_o       = status_q;
    item_count_o   = COUNT_W'(count_q);
  end

endmodule

// File: sim/indexed_list_insert_remove_tb.sv
// indexed_list_insert_remove_tb: self-checking bench for the indexed slot list
// depends on ilir_pkg and indexed_list_insert_remove; a scoreboard class predicts each result beat
`timescale 1ns / 1ps

module indexed_list_insert_remove_tb;
  import ilir_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam logic [POS_W-1:0] POS_TOP = '1;
  localparam int RANDOM_REQUESTS = 1900;
  localparam int MAX_PRINTED = 100;

  // one expected result beat
  typedef struct packed {
    logic [DATA_W-1:0]  data;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  // list predictor plus queue of pending result beats
  class list_scoreboard;
    logic [DATA_W-1:0] entries[$];
    list_result_t      pending_q[$];
    int unsigned       n_err;
    int unsigned       n_checked;
    int unsigned       n_full;
    int unsigned       n_range;
    int unsigned       peak_fill;
    int unsigned       n_mode[8];

    function int unsigned fill_level();
      return entries.size();
    endfunction

    function int unsigned outstanding();
      return pending_q.size();
    endfunction

    task report_mismatch(input string msg);
      n_err++;
      if (n_err <= MAX_PRINTED) $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    // apply one accepted request beat to the list and queue its result
    function void note_request(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                               input logic [DATA_W-1:0] val);
      list_result_t r;
      r.data   = '0;
      r.status = STATUS_OK;
      n_mode[mode]++;
      case (mode)
        MODE_INSERT: begin
          if (pos > entries.size()) r.status = STATUS_RANGE;
          else if (entries.size() >= DEPTH) r.status = STATUS_FULL;
          else entries.insert(pos, val);
        end
        MODE_REMOVE: begin
          if (pos >= entries.size()) r.status = STATUS_RANGE;
          else begin
            r.data = entries[pos];
            entries.delete(pos);
          end
        end
        MODE_READ: begin
          if (pos >= entries.size()) r.status = STATUS_RANGE;
          else r.data = entries[pos];
        end
        MODE_WRITE: begin
          if (pos >= entries.size()) r.status = STATUS_RANGE;
          else entries[pos] = val;
        end
        MODE_CLEAR: entries.delete();
        default: ;
      endcase
      r.count = COUNT_W'(entries.size());
      if (r.status == STATUS_FULL) n_full++;
      if (r.status == STATUS_RANGE) n_range++;
      if (entries.size() > peak_fill) peak_fill = entries.size();
      pending_q.push_back(r);
    endfunction

    // compare one result beat with the oldest expectation
    task check_result(input logic [DATA_W-1:0] data, input logic [STATUS_W-1:0] status,
                      input logic [COUNT_W-1:0] cnt);
      list_result_t exp;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending (data %h status %0d count %0d)",
                                  data, status, cnt));
        return;
      end
      exp = pending_q.pop_front();
      n_checked++;
      if (data !== exp.data)
        report_mismatch($sformatf("data_out %h, expected %h", data, exp.data));
      if (status !== exp.status)
        report_mismatch($sformatf("status %0d, expected %0d", status, exp.status));
      if (cnt !== exp.count)
        report_mismatch($sformatf("item_count %0d, expected %0d", cnt, exp.count));
    endtask

    // anything still pending at the end is a lost beat
    task flush_leftovers();
      while (pending_q.size() > 0) begin
        report_mismatch($sformatf("expected beat never arrived (status %0d count %0d)",
                                  pending_q[0].status, pending_q[0].count));
        void'(pending_q.pop_front());
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [MODE_W-1:0]   mode_i;
  logic [POS_W-1:0]    position_i;
  logic [DATA_W-1:0]   element_value_i;
  logic                result_valid_o;
  logic [DATA_W-1:0]   data_out_o;
  logic [STATUS_W-1:0] status_o;
  logic [COUNT_W-1:0]  item_count_o;

  list_scoreboard sb = new();
  bit gaps_on;
  bit list_growing;

  indexed_list_insert_remove #(
    .CAPACITY   (DEPTH),
    .ELEM_WIDTH (DATA_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .mode_i          (mode_i),
    .position_i      (position_i),
    .element_value_i (element_value_i),
    .result_valid_o  (result_valid_o),
    .data_out_o      (data_out_o),
    .status_o        (status_o),
    .item_count_o    (item_count_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result beats are checked at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) sb.check_result(data_out_o, status_o, item_count_o);
  end

  // present one request beat, with random idle cycles first, and wait for acceptance
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 23) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i         <= 1'b1;
    mode_i          <= mode;
    position_i      <= pos;
    element_value_i <= val;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_request(mode, pos, val);
  endtask

  // random request, mostly legal positions, with the fill level swinging between empty and full
  task automatic send_random_request();
    int unsigned       fill;
    int unsigned       roll;
    int unsigned       t_ins;
    int unsigned       t_rem;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    fill = sb.fill_level();
    if (fill == DEPTH && $urandom_range(99) < 30) list_growing = 1'b0;
    else if (fill == 0 && $urandom_range(99) < 30) list_growing = 1'b1;
    else if ($urandom_range(99) < 2) list_growing = !list_growing;

    t_ins = list_growing ? 50 : 15;
    t_rem = t_ins + (list_growing ? 15 : 50);
    roll  = $urandom_range(99);
    if (roll < 4) mode = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
    else if (roll < 6) mode = MODE_CLEAR;
    else begin
      roll = $urandom_range(99);
      if (roll < t_ins) mode = MODE_INSERT;
      else if (roll < t_rem) mode = MODE_REMOVE;
      else if (roll < t_rem + (100 - t_rem) / 2) mode = MODE_READ;
      else mode = MODE_WRITE;
    end

    if ($urandom_range(99) < 15) pos = POS_W'($urandom_range(POS_TOP, 0));
    else if (mode == MODE_INSERT) pos = POS_W'($urandom_range(fill, 0));
    else pos = (fill > 0) ? POS_W'($urandom_range(fill - 1, 0)) : '0;

    roll = $urandom_range(99);
    if (roll < 10) val = '0;
    else if (roll < 20) val = '1;
    else val = $urandom;
    send_request(mode, pos, val);
  endtask

  // bench watchdog
  initial begin
    #5_000_000;
    $display("[indexed_list_insert_remove] ERROR");
    $finish;
  end

  // main stimulus
  initial begin
    int unsigned wait_cycles;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    mode_i          = MODE_CLEAR;
    position_i      = '0;
    element_value_i = '0;
    gaps_on         = 1'b1;
    list_growing    = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty list refusals
    send_request(MODE_READ, '0, '0);
    send_request(MODE_REMOVE, '0, '0);
    send_request(MODE_WRITE, '0, 32'h1234_5678);
    send_request(MODE_INSERT, 5'd1, 32'h1111_1111);
    // first entries, write one past the end, insert at end and middle
    send_request(MODE_INSERT, '0, '0);
    send_request(MODE_WRITE, 5'd1, 32'hdead_beef);
    send_request(MODE_INSERT, 5'd1, '1);
    send_request(MODE_INSERT, 5'd1, 32'ha5a5_a5a5);
    send_request(MODE_READ, 5'd2, '0);
    // fill to capacity, then refused inserts: full, and past the end on a full list
    while (sb.fill_level() < DEPTH)
      send_request(MODE_INSERT, POS_W'($urandom_range(sb.fill_level(), 0)), $urandom);
    send_request(MODE_INSERT, 5'd16, 32'h5555_5555);
    send_request(MODE_INSERT, POS_TOP, 32'h5555_5555);
    send_request(MODE_READ, 5'd15, '0);
    send_request(MODE_REMOVE, 5'd15, '0);
    send_request(MODE_REMOVE, '0, '0);
    // unused modes leave the list alone
    send_request(MODE_SPARE_LO, '0, '1);
    send_request(MODE_SPARE_HI, POS_TOP, '1);
    send_request(MODE_CLEAR, '0, '0);

    // random part, one long stretch with no idle cycles
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      gaps_on = !(i >= 700 && i < 1000);
      send_random_request();
    end
    @(negedge clk_i);
    start_i <= 1'b0;

    // drain, then allow for the longest read chain
    wait_cycles = 0;
    while (sb.outstanding() > 0 && wait_cycles < 1000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (24) @(posedge clk_i);
    sb.flush_leftovers();

    $display("checked %0d result beats: %0d inserts, %0d removes, %0d reads, %0d writes, %0d clears",
             sb.n_checked, sb.n_mode[MODE_INSERT], sb.n_mode[MODE_REMOVE], sb.n_mode[MODE_READ],
             sb.n_mode[MODE_WRITE], sb.n_mode[MODE_CLEAR]);
    $display("peak fill %0d, %0d full refusals, %0d out-of-range refusals, %0d mismatches",
             sb.peak_fill, sb.n_full, sb.n_range, sb.n_err);
    if (sb.n_err == 0) begin
      $display("[indexed_list_insert_remove] OK");
    end else begin
      $display("[indexed_list_insert_remove] ERROR");
    end
    $finish;
  end

endmodule
